/* sv/lcdtbf_pkg.sv */
`default_nettype none
package lcdtbf_pkg;

  localparam int unsigned VRAM_ADDR_W = 13;
  localparam int unsigned CFG_INDEX_W = 2;
  localparam int unsigned CFG_DATA_W  = 8;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_XFER   = 2'd3
  } lcd_mode_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_WRITE = 2'd1,
    CMD_FETCH = 2'd2,
    CMD_NONE  = 2'd3
  } lcd_cmd_t;

  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_X   = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCROLL_Y   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_SELECT = 2'd2;

  // Dots spent in each mode before it moves on.
  localparam logic [8:0] DOTS_HBLANK = 9'd204;
  localparam logic [8:0] DOTS_VBLANK = 9'd456;
  localparam logic [8:0] DOTS_OAM    = 9'd80;
  localparam logic [8:0] DOTS_XFER   = 9'd172;

  localparam logic [7:0] LINE_VBLANK_START = 8'd143;
  localparam logic [7:0] LINE_FRAME_DONE   = 8'd144;
  localparam logic [7:0] LINE_LAST         = 8'd153;

  // Tile maps sit at 0x1800 and 0x1c00: the top two address bits are set.
  localparam logic [1:0] MAP_BASE_TOP = 2'b11;

endpackage
`default_nettype wire

/* sv/lcd_timing_and_background_fetch.sv */
// A tick, a video memory write or an unused command passes the execute
// state before its done strobe; a pixel fetch goes on through the map, low
// plane and high plane states, as its three reads (map byte, low plane, high
// plane) use the single port of the video memory one after another. A new
// item can be accepted in the cycle that done is high, not while one is busy.
// Synchronous rst gives OAM mode, line 0, dot 0; the receiver cannot stall.
`default_nettype none
module lcd_timing_and_background_fetch (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [1:0]                          cmd,
  input  wire logic [lcdtbf_pkg::VRAM_ADDR_W-1:0]  mem_addr,
  input  wire logic [7:0]                          mem_data,
  input  wire logic [7:0]                          column,
  input  wire logic                                cfg_we,
  input  wire logic [lcdtbf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire logic [lcdtbf_pkg::CFG_DATA_W-1:0]   cfg_data,
  output logic                                     done,
  output logic [1:0]                               mode_now,
  output logic [7:0]                               line_now,
  output logic                                     vblank_irq,
  output logic                                     frame_done,
  output logic                                     line_render,
  output logic [1:0]                               pixel,
  output logic                                     pixel_valid
);

  import lcdtbf_pkg::*;

  // The sequencer walks an item through execution and, for a fetch, through
  // the three dependent video memory reads.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MAP,
    ST_LO,
    ST_HI
  } state_t;

  state_t    state;
  lcd_mode_t mode_reg;
  logic [7:0] line_count;
  logic [8:0] dot_count;

  logic [7:0] scroll_x;
  logic [7:0] scroll_y;
  logic       map_select;

  // Item captured at acceptance.
  lcd_cmd_t                 item_cmd;
  logic [VRAM_ADDR_W-1:0]   item_addr;
  logic [7:0]               item_data;
  logic [7:0]               item_column;

  // Fetch working registers.
  logic [2:0]             fine_x;
  logic [VRAM_ADDR_W-1:0] row_addr;
  logic [7:0]             plane_lo;

  // Video memory port.
  logic                   ram_we;
  logic [VRAM_ADDR_W-1:0] ram_addr;
  logic [7:0]             ram_rdata;

  // Background coordinates of the requested pixel.
  logic [7:0] px;
  logic [7:0] py;

  // Tick arithmetic: one increment, one threshold compare and subtract.
  logic [8:0] dot_inc;
  logic [8:0] dot_limit;
  logic       dot_over;
  logic [8:0] dot_after;
  logic [7:0] line_inc;

  assign busy     = (state != ST_IDLE);
  assign mode_now = mode_reg;
  assign line_now = line_count;

  assign px = scroll_x + item_column;
  assign py = line_count + scroll_y;

  always_comb begin
    unique case (mode_reg)
      MODE_HBLANK: dot_limit = DOTS_HBLANK;
      MODE_VBLANK: dot_limit = DOTS_VBLANK;
      MODE_OAM:    dot_limit = DOTS_OAM;
      MODE_XFER:   dot_limit = DOTS_XFER;
      default:     dot_limit = DOTS_XFER;
    endcase
    dot_inc   = dot_count + 9'd1;
    dot_over  = (dot_inc >= dot_limit);
    dot_after = dot_over ? (dot_inc - dot_limit) : dot_inc;
    line_inc  = line_count + 8'd1;
  end

  // The memory address follows the sequencer: the written byte or the map
  // entry while executing, then the low and high bytes of the tile row.
  always_comb begin
    ram_we   = 1'b0;
    ram_addr = item_addr;
    unique case (state)
      ST_EXEC: begin
        if (item_cmd == CMD_WRITE) begin
          ram_we = 1'b1;
        end else begin
          ram_addr = {MAP_BASE_TOP, map_select, py[7:3], px[7:3]};
        end
      end
      ST_MAP: ram_addr = {1'b0, ram_rdata, py[2:0], 1'b0};
      ST_LO:  ram_addr = {row_addr[VRAM_ADDR_W-1:1], 1'b1};
      default: ram_addr = item_addr;
    endcase
  end

  lcdtbf_ram #(
    .WIDTH(8),
    .DEPTH(2 ** VRAM_ADDR_W)
  ) u_vram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(item_data),
    .rdata(ram_rdata)
  );

  // Configuration registers; an index past the list is ignored.
  always_ff @(posedge clk) begin
    if (rst) begin
      scroll_x   <= '0;
      scroll_y   <= '0;
      map_select <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SCROLL_X:   scroll_x   <= cfg_data;
        REG_SCROLL_Y:   scroll_y   <= cfg_data;
        REG_MAP_SELECT: map_select <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      item_cmd    <= lcd_cmd_t'(cmd);
      item_addr   <= mem_addr;
      item_data   <= mem_data;
      item_column <= column;
    end
    if (state == ST_EXEC) begin
      fine_x <= px[2:0];
    end
    if (state == ST_MAP) begin
      row_addr <= ram_addr;
    end
    if (state == ST_LO) begin
      plane_lo <= ram_rdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      mode_reg    <= MODE_OAM;
      line_count  <= '0;
      dot_count   <= '0;
      done        <= 1'b0;
      vblank_irq  <= 1'b0;
      frame_done  <= 1'b0;
      line_render <= 1'b0;
      pixel       <= '0;
      pixel_valid <= 1'b0;
    end else begin
      done        <= 1'b0;
      vblank_irq  <= 1'b0;
      frame_done  <= 1'b0;
      line_render <= 1'b0;
      pixel       <= '0;
      pixel_valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            state <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          if (item_cmd == CMD_FETCH) begin
            state <= ST_MAP;
          end else begin
            state <= ST_IDLE;
            done  <= 1'b1;
          end
          if (item_cmd == CMD_TICK) begin
            dot_count <= dot_after;
            if (dot_over) begin
              unique case (mode_reg)
                MODE_HBLANK: begin
                  line_count <= line_inc;
                  if (line_inc == LINE_VBLANK_START) begin
                    vblank_irq <= 1'b1;
                    mode_reg   <= MODE_VBLANK;
                  end else begin
                    mode_reg <= MODE_OAM;
                  end
                end
                MODE_VBLANK: begin
                  frame_done <= (line_inc == LINE_FRAME_DONE);
                  if (line_inc > LINE_LAST) begin
                    line_count <= '0;
                    mode_reg   <= MODE_OAM;
                  end else begin
                    line_count <= line_inc;
                  end
                end
                MODE_OAM: mode_reg <= MODE_XFER;
                MODE_XFER: begin
                  mode_reg    <= MODE_HBLANK;
                  line_render <= 1'b1;
                end
                default: mode_reg <= MODE_OAM;
              endcase
            end
          end
        end
        ST_MAP: state <= ST_LO;
        ST_LO:  state <= ST_HI;
        ST_HI: begin
          // Bit 7 - fine_x of each plane; 7 - x is ~x on three bits.
          state       <= ST_IDLE;
          done        <= 1'b1;
          pixel_valid <= 1'b1;
          pixel       <= {ram_rdata[~fine_x], plane_lo[~fine_x]};
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A result always coincides with the sequencer being free again.
  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobe while the sequencer is still busy");

  a_pixel_done: assert property (@(posedge clk) disable iff (rst)
    (pixel_valid || vblank_irq || frame_done || line_render) |-> done)
    else $error("result flag raised without a result strobe");

  a_irq_line: assert property (@(posedge clk) disable iff (rst)
    vblank_irq |-> (mode_now == MODE_VBLANK) && (line_now == LINE_VBLANK_START))
    else $error("vertical blank entered at the wrong line");

  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    frame_done |-> (mode_now == MODE_VBLANK) && (line_now == LINE_FRAME_DONE))
    else $error("frame completion reported at the wrong line");

  a_render_mode: assert property (@(posedge clk) disable iff (rst)
    line_render |-> (mode_now == MODE_HBLANK) && !pixel_valid)
    else $error("line render pulse outside the move to horizontal blank");

endmodule
`default_nettype wire

/* sv/lcdtbf_ram.sv */
`default_nettype none
module lcdtbf_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8192
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule
`default_nettype wire

/* tb/lcd_timing_and_background_fetch_tb.sv */
`timescale 1ns / 100ps

// Self-checking bench for the LCD timing and background fetch block.
// Items go in through the start/busy handshake. Every accepted item is run
// through a cycle-free model of the display timing and the video memory.
// The model gives one expected status per item. A checker compares each done
// strobe against the oldest status still pending.
module lcd_timing_and_background_fetch_tb;
  import lcdtbf_pkg::*;

  // Base addresses of the two background tile maps.
  localparam logic [VRAM_ADDR_W-1:0] MAP0_BASE = 13'h1800;
  localparam logic [VRAM_ADDR_W-1:0] MAP1_BASE = 13'h1c00;
  // The register port has room for one index that maps to no register.
  localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;
  localparam int unsigned VRAM_DEPTH = 1 << VRAM_ADDR_W;
  localparam int unsigned MAX_REPORTS = 10;

  typedef struct {
    lcd_cmd_t               op;
    logic [VRAM_ADDR_W-1:0] addr;
    logic [7:0]             data;
    logic [7:0]             column;
  } lcd_item_t;

  typedef struct {
    lcd_mode_t  mode;
    logic [7:0] line;
    logic       irq;
    logic       frame;
    logic       render;
    logic [1:0] pixel;
    logic       pixel_valid;
  } lcd_status_t;

  logic                   clk;
  logic                   rst;
  logic                   start;
  logic                   busy;
  logic [1:0]             cmd;
  logic [VRAM_ADDR_W-1:0] mem_addr;
  logic [7:0]             mem_data;
  logic [7:0]             column;
  logic                   cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;
  logic                   done;
  logic [1:0]             mode_now;
  logic [7:0]             line_now;
  logic                   vblank_irq;
  logic                   frame_done;
  logic                   line_render;
  logic [1:0]             pixel;
  logic                   pixel_valid;

  lcd_timing_and_background_fetch dut (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .cmd         (cmd),
    .mem_addr    (mem_addr),
    .mem_data    (mem_data),
    .column      (column),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .done        (done),
    .mode_now    (mode_now),
    .line_now    (line_now),
    .vblank_irq  (vblank_irq),
    .frame_done  (frame_done),
    .line_render (line_render),
    .pixel       (pixel),
    .pixel_valid (pixel_valid)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Shadow copy of the display state and of the video memory. The written
  // flags keep every fetch away from bytes that hold no defined value yet.
  logic [7:0] vram_shadow [0:VRAM_DEPTH-1];
  bit         vram_written [0:VRAM_DEPTH-1];
  lcd_mode_t  mode_shadow;
  logic [7:0] line_shadow;
  logic [8:0] dot_shadow;
  logic [7:0] scx_shadow;
  logic [7:0] scy_shadow;
  logic       map_hi_shadow;

  // Statuses predicted for accepted items, oldest first.
  lcd_status_t pending_status [$];
  lcd_status_t oldest;

  int unsigned mismatch_count;
  int unsigned results_seen;
  int unsigned ticks_sent;
  int unsigned writes_sent;
  int unsigned fetches_sent;
  int unsigned unused_sent;
  int unsigned vblank_entries;
  int unsigned frames_finished;
  int unsigned line_renders;
  int unsigned settings_used;

  // Address of the tile map entry that covers a column of the current line.
  function automatic logic [VRAM_ADDR_W-1:0] map_entry_addr(logic [7:0] col);
    logic [7:0] px;
    logic [7:0] py;
    px = scx_shadow + col;
    py = line_shadow + scy_shadow;
    return (map_hi_shadow ? MAP1_BASE : MAP0_BASE) + {3'b000, py[7:3], px[7:3]};
  endfunction

  // Address of the low plane byte of the tile row that the column lands on.
  // The high plane byte follows it.
  function automatic logic [VRAM_ADDR_W-1:0] tile_row_addr(logic [7:0] col);
    logic [7:0] py;
    logic [7:0] tile;
    py = line_shadow + scy_shadow;
    tile = vram_shadow[map_entry_addr(col)];
    return {1'b0, tile, py[2:0], 1'b0};
  endfunction

  // Applies one item to the shadow state and returns the status it causes.
  function automatic lcd_status_t advance_lcd(lcd_item_t it);
    lcd_status_t s;
    logic [7:0] px;
    logic [VRAM_ADDR_W-1:0] row;
    logic [2:0] b;
    s.irq = 1'b0;
    s.frame = 1'b0;
    s.render = 1'b0;
    s.pixel = 2'd0;
    s.pixel_valid = 1'b0;
    case (it.op)
      CMD_TICK: begin
        dot_shadow = dot_shadow + 9'd1;
        case (mode_shadow)
          MODE_HBLANK: begin
            if (dot_shadow >= DOTS_HBLANK) begin
              line_shadow = line_shadow + 8'd1;
              if (line_shadow == LINE_VBLANK_START) begin
                s.irq = 1'b1;
                mode_shadow = MODE_VBLANK;
              end else begin
                mode_shadow = MODE_OAM;
              end
              dot_shadow = dot_shadow - DOTS_HBLANK;
            end
          end
          MODE_VBLANK: begin
            if (dot_shadow >= DOTS_VBLANK) begin
              line_shadow = line_shadow + 8'd1;
              if (line_shadow == LINE_FRAME_DONE) s.frame = 1'b1;
              if (line_shadow > LINE_LAST) begin
                line_shadow = 8'd0;
                mode_shadow = MODE_OAM;
              end
              dot_shadow = dot_shadow - DOTS_VBLANK;
            end
          end
          MODE_OAM: begin
            if (dot_shadow >= DOTS_OAM) begin
              mode_shadow = MODE_XFER;
              dot_shadow = dot_shadow - DOTS_OAM;
            end
          end
          default: begin
            if (dot_shadow >= DOTS_XFER) begin
              mode_shadow = MODE_HBLANK;
              s.render = 1'b1;
              dot_shadow = dot_shadow - DOTS_XFER;
            end
          end
        endcase
      end
      CMD_WRITE: begin
        vram_shadow[it.addr] = it.data;
        vram_written[it.addr] = 1'b1;
      end
      CMD_FETCH: begin
        px = scx_shadow + it.column;
        row = tile_row_addr(it.column);
        b = 3'd7 - px[2:0];
        s.pixel = {vram_shadow[row + 13'd1][b], vram_shadow[row][b]};
        s.pixel_valid = 1'b1;
      end
      default: begin
        // The unused command leaves everything as it was.
      end
    endcase
    s.mode = mode_shadow;
    s.line = line_shadow;
    vblank_entries += s.irq;
    frames_finished += s.frame;
    line_renders += s.render;
    return s;
  endfunction

  // Mostly back-to-back items, some short pauses and now and then a long one.
  function automatic int unsigned pick_gap(int unsigned idle_pct);
    if ($urandom_range(99) >= idle_pct) return 0;
    if ($urandom_range(9) < 8) return $urandom_range(3, 1);
    return $urandom_range(40, 4);
  endfunction

  // Every field gets random content, also those that the command ignores.
  function automatic lcd_item_t random_item(lcd_cmd_t op);
    lcd_item_t it;
    it.op = op;
    it.addr = VRAM_ADDR_W'($urandom_range(VRAM_DEPTH - 1));
    it.data = 8'($urandom_range(255));
    it.column = 8'($urandom_range(255));
    return it;
  endfunction

  // Presents one item after the pause that gap gives and holds it until the
  // block takes it. The prediction is made at the accepting edge, so it sees
  // the state left by all earlier items.
  task automatic issue_item(lcd_item_t it, int unsigned gap);
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    start <= 1'b1;
    cmd <= it.op;
    mem_addr <= it.addr;
    mem_data <= it.data;
    column <= it.column;
    do @(posedge clk); while (busy);
    pending_status.push_back(advance_lcd(it));
    case (it.op)
      CMD_TICK:  ticks_sent++;
      CMD_WRITE: writes_sent++;
      CMD_FETCH: fetches_sent++;
      default:   unused_sent++;
    endcase
  endtask

  // Stops sending, lets every pending status come back and then waits on
  // so that the block is idle for sure.
  task automatic wait_for_results();
    @(negedge clk);
    start <= 1'b0;
    while (pending_status.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_SCROLL_X:   scx_shadow = value;
      REG_SCROLL_Y:   scy_shadow = value;
      REG_MAP_SELECT: map_hi_shadow = value[0];
      default: begin
        // No register behind this index.
      end
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic configure(logic [7:0] scx, logic [7:0] scy, logic map_hi);
    wait_for_results();
    write_register(REG_SCROLL_X, scx);
    write_register(REG_SCROLL_Y, scy);
    write_register(REG_MAP_SELECT, {7'($urandom_range(127)), map_hi});
    settings_used++;
  endtask

  // Fetches one column. Any map entry or tile row byte that the fetch would
  // read and that nothing has written yet gets a random byte first.
  task automatic fetch_column(logic [7:0] col, int unsigned idle_pct);
    lcd_item_t it;
    logic [VRAM_ADDR_W-1:0] a;
    a = map_entry_addr(col);
    if (!vram_written[a]) begin
      it = random_item(CMD_WRITE);
      it.addr = a;
      issue_item(it, pick_gap(idle_pct));
    end
    a = tile_row_addr(col);
    for (int k = 0; k < 2; k++) begin
      if (!vram_written[a + VRAM_ADDR_W'(k)]) begin
        it = random_item(CMD_WRITE);
        it.addr = a + VRAM_ADDR_W'(k);
        issue_item(it, pick_gap(idle_pct));
      end
    end
    it = random_item(CMD_FETCH);
    it.column = col;
    issue_item(it, pick_gap(idle_pct));
  endtask

  task automatic write_byte(logic [VRAM_ADDR_W-1:0] addr, logic [7:0] value, int unsigned gap);
    lcd_item_t it;
    it = random_item(CMD_WRITE);
    it.addr = addr;
    it.data = value;
    issue_item(it, gap);
  endtask

  // Writes spread over the whole memory, with a bias toward the tile maps and
  // the tile data so that later fetches find their bytes already in place.
  task automatic random_write(int unsigned idle_pct);
    lcd_item_t it;
    it = random_item(CMD_WRITE);
    case ($urandom_range(3))
      2:       it.addr = MAP0_BASE + VRAM_ADDR_W'($urandom_range(2047));
      3:       it.addr = VRAM_ADDR_W'($urandom_range(4095));
      default: begin
      end
    endcase
    issue_item(it, pick_gap(idle_pct));
  endtask

  // Field extremes, every command, columns past the visible line, scroll
  // wrap-around, both tile maps and a write to the unused register index.
  task automatic test_directed();
    lcd_item_t it;
    configure(8'd0, 8'd0, 1'b0);
    write_byte(13'h0000, 8'hff, 0);
    write_byte(13'h1fff, 8'h00, 0);
    write_byte(MAP0_BASE, 8'h00, 1);
    fetch_column(8'd0, 0);
    fetch_column(8'd159, 0);
    fetch_column(8'd160, 0);
    fetch_column(8'd255, 0);
    it.op = CMD_NONE;
    it.addr = 13'h1fff;
    it.data = 8'hff;
    it.column = 8'hff;
    issue_item(it, 0);
    for (int k = 0; k < 3; k++) issue_item(random_item(CMD_TICK), k);
    configure(8'd255, 8'd255, 1'b1);
    write_register(REG_UNUSED, 8'hff);
    fetch_column(8'd0, 0);
    fetch_column(8'd255, 0);
    wait_for_results();
    // Only bit 0 of the map select data counts.
    write_register(REG_MAP_SELECT, 8'hfe);
    fetch_column(8'd159, 0);
    write_byte(13'h1fff, 8'hff, 2);
    fetch_column(8'd160, 0);
  endtask

  // Random mix of all commands under several register settings, one of the
  // phases with no random gaps between items.
  task automatic test_random_mix();
    int unsigned idle_pct;
    int unsigned pick;
    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0:       configure(8'd0, 8'd255, 1'b1);
        1:       configure(8'd255, 8'd0, 1'b0);
        default: configure(8'($urandom_range(255)), 8'($urandom_range(255)),
                           1'($urandom_range(1)));
      endcase
      idle_pct = (phase == 2) ? 0 : 35;
      for (int n = 0; n < 325; n++) begin
        pick = $urandom_range(99);
        if (pick < 40) issue_item(random_item(CMD_TICK), pick_gap(idle_pct));
        else if (pick < 65) random_write(idle_pct);
        else if (pick < 95) fetch_column(8'($urandom_range(255)), idle_pct);
        else issue_item(random_item(CMD_NONE), pick_gap(idle_pct));
        // Now and then let the pipeline run dry before going on.
        if ($urandom_range(99) == 0) wait_for_results();
      end
    end
  endtask

  // Ticks through a whole frame and into the next one: vertical blank entry,
  // the frame pulse and the wrap after the last line. Fetches and writes are
  // sprinkled in, so some land in every mode, vertical blank included.
  task automatic test_frame_sweep();
    bit wrapped;
    logic [7:0] prev_line;
    int unsigned pick;
    int unsigned n;
    wrapped = 1'b0;
    n = 0;
    configure(8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
    while (!(wrapped && line_shadow >= 8'd2)) begin
      prev_line = line_shadow;
      pick = $urandom_range(199);
      if (pick == 0) fetch_column(8'($urandom_range(255)), 5);
      else if (pick == 1) random_write(5);
      else issue_item(random_item(CMD_TICK), pick_gap(5));
      if (prev_line == LINE_LAST && line_shadow == 8'd0) wrapped = 1'b1;
      n++;
      if (n % 20000 == 0) begin
        configure(8'($urandom_range(255)), 8'($urandom_range(255)), 1'($urandom_range(1)));
      end
    end
  endtask

  // Each done strobe is one status, taken at the edge that ends its cycle.
  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      results_seen++;
      if (pending_status.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
          $display("%0t: status with no item waiting for it", $realtime);
        end
      end else begin
        oldest = pending_status.pop_front();
        if (mode_now !== oldest.mode || line_now !== oldest.line ||
            vblank_irq !== oldest.irq || frame_done !== oldest.frame ||
            line_render !== oldest.render || pixel !== oldest.pixel ||
            pixel_valid !== oldest.pixel_valid) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS) begin
            $display("%0t: status mismatch: mode/line/irq/frame/render/pixel/valid", $realtime);
            $display("  wanted %0d %0d %0b %0b %0b %0d %0b", oldest.mode, oldest.line,
                     oldest.irq, oldest.frame, oldest.render, oldest.pixel,
                     oldest.pixel_valid);
            $display("  got    %0d %0d %0b %0b %0b %0d %0b", mode_now, line_now,
                     vblank_irq, frame_done, line_render, pixel, pixel_valid);
          end
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_TICK;
    mem_addr = '0;
    mem_data = '0;
    column = '0;
    cfg_we = 1'b0;
    cfg_index = REG_SCROLL_X;
    cfg_data = '0;
    mode_shadow = MODE_OAM;
    line_shadow = 8'd0;
    dot_shadow = 9'd0;
    scx_shadow = 8'd0;
    scy_shadow = 8'd0;
    map_hi_shadow = 1'b0;
    for (int a = 0; a < VRAM_DEPTH; a++) begin
      vram_shadow[a] = 8'd0;
      vram_written[a] = 1'b0;
    end
    mismatch_count = 0;
    results_seen = 0;
    ticks_sent = 0;
    writes_sent = 0;
    fetches_sent = 0;
    unused_sent = 0;
    vblank_entries = 0;
    frames_finished = 0;
    line_renders = 0;
    settings_used = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed();
    test_random_mix();
    test_frame_sweep();

    wait_for_results();
    repeat (10) @(posedge clk);
    $display("Run covered %0d ticks, %0d memory writes, %0d fetches, %0d unused commands",
             ticks_sent, writes_sent, fetches_sent, unused_sent);
    $display("with %0d renders, %0d vblank entries, %0d frames, %0d scroll/map settings",
             line_renders, vblank_entries, frames_finished, settings_used);
    if (mismatch_count == 0 && pending_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // Far beyond the slowest correct run.
  initial begin
    #50000000;
    $display("Verification failed");
    $finish;
  end

endmodule
